// ===== src/assert_macros.svh =====
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication in the same cycle, ignored while reset is high.
`define CHK_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Implication into the next cycle, ignored while reset is high.
`define CHK_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

// Implication into the next cycle that also holds across reset.
`define CHK_NEXT_ALWAYS(label, clk, ante, cons, msg) \
   label: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

// ===== src/itoaf_pkg.sv =====
package itoaf_pkg;

   localparam int MaxWidthDefault = 63;
   localparam int DigitCap        = 22;
   localparam int DecDigits       = 20;
   localparam int HexDigits       = 16;
   localparam int ConvSteps       = 64;
   localparam int QueueDepth      = 2;
   localparam int FrameMax        = 63;

   typedef enum logic [2:0] {
      KIND_SDEC  = 3'd0,
      KIND_UDEC  = 3'd1,
      KIND_HEXL  = 3'd2,
      KIND_HEXU  = 3'd3,
      KIND_OCT   = 3'd4,
      KIND_CHAR  = 3'd5
   } kind_type;

   typedef enum logic [1:0] {
      SIGN_NONE  = 2'd0,
      SIGN_PLUS  = 2'd1,
      SIGN_SPACE = 2'd2
   } sign_mode_type;

   typedef enum logic [1:0] {
      RADIX_DEC,
      RADIX_HEX,
      RADIX_OCT,
      RADIX_CHAR
   } radix_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CONV,
      ST_COUNT,
      ST_SIGN,
      ST_PRE,
      ST_DIG,
      ST_POST
   } back_state_type;

   localparam logic [7:0] ChZero  = 8'h30;
   localparam logic [7:0] ChMinus = 8'h2d;
   localparam logic [7:0] ChPlus  = 8'h2b;
   localparam logic [7:0] ChSpace = 8'h20;
   localparam logic [7:0] ChUpperA = 8'h41;
   localparam logic [7:0] ChLowerA = 8'h61;

   typedef struct packed {
      radix_type   radix;
      logic        upper;
      logic [63:0] mag;
      logic        has_sign;
      logic [7:0]  sign_char;
      logic [5:0]  width;
      logic        left;
      logic        zero;
   } job_type;

   function automatic logic [7:0] digit_char(input logic [3:0] d, input logic upper);
      logic [7:0] base_ch;
      base_ch = upper ? ChUpperA : ChLowerA;
      if (d < 4'd10) begin
         return ChZero + {4'b0, d};
      end
      return base_ch + {4'b0, d} - 8'd10;
   endfunction

endpackage

// ===== src/itoaf_queue.sv =====
module itoaf_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  itoaf_pkg::job_type push_data,
   output logic              full,
   input  logic              pop,
   output logic              not_empty,
   output itoaf_pkg::job_type pop_data
);

   localparam int PtrW = (itoaf_pkg::QueueDepth > 1) ? $clog2(itoaf_pkg::QueueDepth) : 1;
   localparam int CntW = $clog2(itoaf_pkg::QueueDepth + 1);
   localparam logic [CntW-1:0] DepthC = CntW'(itoaf_pkg::QueueDepth);
   localparam logic [PtrW-1:0] LastPtr = PtrW'(itoaf_pkg::QueueDepth - 1);

   itoaf_pkg::job_type entries_ff [itoaf_pkg::QueueDepth];
   logic [PtrW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0] count_ff, count_in;
   logic            do_push, do_pop;

   assign full      = (count_ff == DepthC);
   assign not_empty = (count_ff != '0);
   assign pop_data  = entries_ff[rd_ptr_ff];
   assign do_push   = push && !full;
   assign do_pop    = pop && not_empty;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == LastPtr) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LastPtr) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (!do_push && do_pop) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entries_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// ===== src/itoaf_front.sv =====
module itoaf_front #(
   parameter int MAX_WIDTH = itoaf_pkg::MaxWidthDefault
) (
   input  logic               req_tvalid,
   output logic               req_tready,
   input  logic [79:0]        req_tdata,
   input  logic [2:0]         req_tuser,
   input  logic               q_full,
   output logic               q_push,
   output itoaf_pkg::job_type q_data
);

   localparam logic [7:0] MaxW = 8'(MAX_WIDTH);

   logic [63:0] value;
   logic        is_wide;
   logic [5:0]  field_width;
   logic        left_justify;
   logic        zero_pad;
   logic [1:0]  sign_mode;
   logic [63:0] v64;
   logic [63:0] negv;
   logic        neg;
   logic        kind_ok;
   logic [7:0]  w8;
   logic [5:0]  w_sat;

   assign value        = req_tdata[63:0];
   assign is_wide      = req_tdata[64];
   assign field_width  = req_tdata[70:65];
   assign left_justify = req_tdata[71];
   assign zero_pad     = req_tdata[72];
   assign sign_mode    = req_tdata[74:73];

   assign req_tready = !q_full;
   assign kind_ok    = (req_tuser <= itoaf_pkg::KIND_CHAR);
   assign q_push     = req_tvalid && !q_full && kind_ok;

   always_comb begin
      v64  = is_wide ? value : {32'b0, value[31:0]};
      negv = 64'(64'd0 - v64);
      neg  = (req_tuser == itoaf_pkg::KIND_SDEC) && (is_wide ? value[63] : value[31]);
      w8   = ({2'b0, field_width} > MaxW) ? MaxW : {2'b0, field_width};
      w_sat = w8[5:0];

      q_data           = '0;
      q_data.upper     = (req_tuser == itoaf_pkg::KIND_HEXU);
      q_data.left      = left_justify;
      q_data.zero      = zero_pad;
      q_data.mag       = neg ? (is_wide ? negv : {32'b0, negv[31:0]}) : v64;
      q_data.has_sign  = neg;
      q_data.sign_char = itoaf_pkg::ChMinus;
      if (!neg && (req_tuser == itoaf_pkg::KIND_SDEC) && (v64 != '0)) begin
         if (sign_mode == itoaf_pkg::SIGN_PLUS) begin
            q_data.has_sign  = 1'b1;
            q_data.sign_char = itoaf_pkg::ChPlus;
         end else if (sign_mode == itoaf_pkg::SIGN_SPACE) begin
            q_data.has_sign  = 1'b1;
            q_data.sign_char = itoaf_pkg::ChSpace;
         end
      end
      q_data.width = (q_data.has_sign && (w_sat != '0)) ? w_sat - 6'd1 : w_sat;

      case (req_tuser)
         itoaf_pkg::KIND_SDEC, itoaf_pkg::KIND_UDEC: begin
            q_data.radix = itoaf_pkg::RADIX_DEC;
         end
         itoaf_pkg::KIND_HEXL, itoaf_pkg::KIND_HEXU: begin
            q_data.radix = itoaf_pkg::RADIX_HEX;
         end
         itoaf_pkg::KIND_OCT: begin
            q_data.radix = itoaf_pkg::RADIX_OCT;
         end
         default: begin
            q_data.radix = itoaf_pkg::RADIX_CHAR;
            q_data.zero  = 1'b0;
            q_data.mag   = {56'b0, value[7:0]};
         end
      endcase
   end

endmodule

// ===== src/itoaf_back.sv =====
module itoaf_back (
   input  logic               clock,
   input  logic               reset,
   input  logic               q_not_empty,
   input  itoaf_pkg::job_type q_data,
   output logic               q_pop,
   output logic               rsp_tvalid,
   input  logic               rsp_tready,
   output logic [7:0]         rsp_tdata,
   output logic               rsp_tlast
);

   localparam int IdxW  = $clog2(itoaf_pkg::DigitCap);
   localparam int StepW = $clog2(itoaf_pkg::ConvSteps);
   localparam int DecW  = 4 * itoaf_pkg::DecDigits;
   localparam int AllW  = 4 * itoaf_pkg::DigitCap;
   localparam logic [StepW-1:0] LastStep = StepW'(itoaf_pkg::ConvSteps - 1);

   itoaf_pkg::back_state_type state_ff, state_in;
   itoaf_pkg::job_type        job_ff, job_in;
   logic [itoaf_pkg::DigitCap-1:0][3:0] digits_ff, digits_in;
   logic [63:0]      shift_ff, shift_in;
   logic [StepW-1:0] step_ff, step_in;
   logic [5:0]       pad_ff, pad_in;
   logic [IdxW-1:0]  idx_ff, idx_in;
   logic             out_valid_ff, out_valid_in;
   logic [7:0]       out_data_ff, out_data_in;
   logic             out_last_ff, out_last_in;

   logic             emit_ok;
   logic [DecW-1:0]  adj;
   logic [65:0]      m66;
   logic [IdxW-1:0]  top;
   logic [5:0]       n6;
   logic             post_pad;

   assign emit_ok    = !out_valid_ff || rsp_tready;
   assign post_pad   = job_ff.left && (pad_ff != '0);
   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff;
   assign rsp_tlast  = out_last_ff;

   always_comb begin
      state_in     = state_ff;
      job_in       = job_ff;
      digits_in    = digits_ff;
      shift_in     = shift_ff;
      step_in      = step_ff;
      pad_in       = pad_ff;
      idx_in       = idx_ff;
      out_valid_in = out_valid_ff && !rsp_tready;
      out_data_in  = out_data_ff;
      out_last_in  = out_last_ff;
      q_pop        = 1'b0;
      m66          = {2'b0, q_data.mag};
      top          = '0;
      n6           = '0;
      for (int i = 0; i < itoaf_pkg::DecDigits; i++) begin
         adj[4*i +: 4] = (digits_ff[i] >= 4'd5) ? digits_ff[i] + 4'd3 : digits_ff[i];
      end

      case (state_ff)
         itoaf_pkg::ST_IDLE: begin
            if (q_not_empty) begin
               q_pop     = 1'b1;
               job_in    = q_data;
               digits_in = '0;
               shift_in  = q_data.mag;
               step_in   = '0;
               state_in  = itoaf_pkg::ST_COUNT;
               case (q_data.radix)
                  itoaf_pkg::RADIX_DEC: begin
                     state_in = itoaf_pkg::ST_CONV;
                  end
                  itoaf_pkg::RADIX_HEX: begin
                     for (int i = 0; i < itoaf_pkg::HexDigits; i++) begin
                        digits_in[i] = q_data.mag[4*i +: 4];
                     end
                  end
                  itoaf_pkg::RADIX_OCT: begin
                     for (int i = 0; i < itoaf_pkg::DigitCap; i++) begin
                        digits_in[i] = {1'b0, m66[3*i +: 3]};
                     end
                  end
                  default: begin
                     digits_in = '0;
                  end
               endcase
            end
         end
         itoaf_pkg::ST_CONV: begin
            digits_in = {{(AllW - DecW){1'b0}}, adj[DecW-2:0], shift_ff[63]};
            shift_in  = {shift_ff[62:0], 1'b0};
            step_in   = step_ff + 1'b1;
            if (step_ff == LastStep) begin
               state_in = itoaf_pkg::ST_COUNT;
            end
         end
         itoaf_pkg::ST_COUNT: begin
            for (int i = 0; i < itoaf_pkg::DigitCap; i++) begin
               if (digits_ff[i] != 4'd0) begin
                  top = IdxW'(i);
               end
            end
            n6     = 6'(top) + 6'd1;
            idx_in = top;
            pad_in = (job_ff.width > n6) ? job_ff.width - n6 : '0;
            if (job_ff.has_sign) begin
               state_in = itoaf_pkg::ST_SIGN;
            end else if (!job_ff.left && (pad_in != '0)) begin
               state_in = itoaf_pkg::ST_PRE;
            end else begin
               state_in = itoaf_pkg::ST_DIG;
            end
         end
         itoaf_pkg::ST_SIGN: begin
            if (emit_ok) begin
               out_valid_in = 1'b1;
               out_data_in  = job_ff.sign_char;
               out_last_in  = 1'b0;
               state_in     = (!job_ff.left && (pad_ff != '0)) ? itoaf_pkg::ST_PRE
                                                               : itoaf_pkg::ST_DIG;
            end
         end
         itoaf_pkg::ST_PRE: begin
            if (emit_ok) begin
               out_valid_in = 1'b1;
               out_data_in  = job_ff.zero ? itoaf_pkg::ChZero : itoaf_pkg::ChSpace;
               out_last_in  = 1'b0;
               pad_in       = pad_ff - 6'd1;
               if (pad_ff == 6'd1) begin
                  state_in = itoaf_pkg::ST_DIG;
               end
            end
         end
         itoaf_pkg::ST_DIG: begin
            if (emit_ok) begin
               out_valid_in = 1'b1;
               out_data_in  = (job_ff.radix == itoaf_pkg::RADIX_CHAR) ? job_ff.mag[7:0]
                              : itoaf_pkg::digit_char(digits_ff[idx_ff], job_ff.upper);
               out_last_in  = (idx_ff == '0) && !post_pad;
               if (idx_ff == '0) begin
                  state_in = post_pad ? itoaf_pkg::ST_POST : itoaf_pkg::ST_IDLE;
               end else begin
                  idx_in = idx_ff - 1'b1;
               end
            end
         end
         itoaf_pkg::ST_POST: begin
            if (emit_ok) begin
               out_valid_in = 1'b1;
               out_data_in  = itoaf_pkg::ChSpace;
               out_last_in  = (pad_ff == 6'd1);
               pad_in       = pad_ff - 6'd1;
               if (pad_ff == 6'd1) begin
                  state_in = itoaf_pkg::ST_IDLE;
               end
            end
         end
         default: begin
            state_in = itoaf_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= itoaf_pkg::ST_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      job_ff      <= job_in;
      digits_ff   <= digits_in;
      shift_ff    <= shift_in;
      step_ff     <= step_in;
      pad_ff      <= pad_in;
      idx_ff      <= idx_in;
      out_data_ff <= out_data_in;
      out_last_ff <= out_last_in;
   end

endmodule

// ===== src/integer_to_ascii_formatter.sv =====
// Formats one printf-style integer or character conversion per request item.
// The req channel carries the operand, flags and width in tdata and the conversion
// kind in tuser; items with an unknown kind are accepted and dropped.
// The rsp channel returns the formatted text, one ASCII character per item, with
// tlast on the final character of each request.
// Requests pass through a two-entry queue, so up to two more requests are taken
// while one is being formatted. A decimal request first runs through the
// double-dabble converter (one bit per cycle), then the formatter finds the top
// digit; hex, octal and character requests skip the converter. Characters then
// leave one per cycle while the receiver holds rsp_tready high.
// When the receiver holds rsp_tready low, the pending character stays on the port
// and formatting pauses; the queue keeps accepting until it is full.
// Synchronous reset empties the queue and drops any request in progress.
module integer_to_ascii_formatter #(
   parameter int MAX_WIDTH = itoaf_pkg::MaxWidthDefault
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // value[63:0], is_wide[64], field_width[70:65], left_justify[71],
   // zero_pad[72], sign_mode[74:73], zero fill above.
   input  logic [79:0] req_tdata,
   // req_type[2:0].
   input  logic [2:0]  req_tuser,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // out_char[7:0].
   output logic [7:0]  rsp_tdata,
   output logic        rsp_tlast
);

   logic               q_full;
   logic               q_push;
   logic               q_pop;
   logic               q_not_empty;
   itoaf_pkg::job_type push_data;
   itoaf_pkg::job_type pop_data;

   itoaf_front #(
      .MAX_WIDTH(MAX_WIDTH)
   ) u_front (
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata (req_tdata),
      .req_tuser (req_tuser),
      .q_full    (q_full),
      .q_push    (q_push),
      .q_data    (push_data)
   );

   itoaf_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (q_push),
      .push_data(push_data),
      .full     (q_full),
      .pop      (q_pop),
      .not_empty(q_not_empty),
      .pop_data (pop_data)
   );

   itoaf_back u_back (
      .clock      (clock),
      .reset      (reset),
      .q_not_empty(q_not_empty),
      .q_data     (pop_data),
      .q_pop      (q_pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

// ===== src/itoaf_checker.sv =====
`include "assert_macros.svh"

module itoaf_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic [79:0] req_tdata,
   input logic [2:0]  req_tuser,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [7:0]  rsp_tdata,
   input logic        rsp_tlast
);

   logic [3:0] pending_ff, pending_in;
   logic [5:0] frame_cnt_ff, frame_cnt_in;
   logic       req_take, rsp_take, rsp_end;

   assign req_take = req_tvalid && req_tready && (req_tuser <= itoaf_pkg::KIND_CHAR);
   assign rsp_take = rsp_tvalid && rsp_tready;
   assign rsp_end  = rsp_take && rsp_tlast;

   always_comb begin
      pending_in   = pending_ff + {3'b0, req_take} - {3'b0, rsp_end};
      frame_cnt_in = frame_cnt_ff;
      if (rsp_end) begin
         frame_cnt_in = '0;
      end else if (rsp_take) begin
         frame_cnt_in = frame_cnt_ff + 6'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff   <= '0;
         frame_cnt_ff <= '0;
      end else begin
         pending_ff   <= pending_in;
         frame_cnt_ff <= frame_cnt_in;
      end
   end

   `CHK_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast), "rsp item changed while stalled")
   `CHK_NEXT_ALWAYS(a_reset_idle, clock, reset, !rsp_tvalid, "rsp_tvalid high right after reset")
   `CHK_SAME(a_no_orphan, clock, reset, rsp_tvalid, pending_ff != '0, "character without an open request")
   `CHK_SAME(a_frame_len, clock, reset, rsp_take && !rsp_tlast, frame_cnt_ff < 6'(itoaf_pkg::FrameMax - 1), "request text longer than the field limit")

endmodule

bind integer_to_ascii_formatter itoaf_checker u_itoaf_checker (.*);

// ===== tb/sv/tb_integer_to_ascii_formatter.sv =====
module tb_integer_to_ascii_formatter;
   timeunit 1ns;
   timeprecision 1ps;

   import itoaf_pkg::*;

   localparam logic [2:0] KIND_RSVD6 = 3'd6;
   localparam logic [2:0] KIND_RSVD7 = 3'd7;
   localparam logic [1:0] SIGN_RSVD  = 2'd3;
   localparam int FieldWidthCap = MaxWidthDefault;
   localparam int CycleLimit    = 3000000;
   localparam int DrainCycles   = 200;

   typedef struct packed {
      logic [7:0] ch;
      logic       last;
   } text_char_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [79:0] req_tdata = '0;
   logic [2:0]  req_tuser = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [7:0]  rsp_tdata;
   logic        rsp_tlast;

   text_char_type expected_text[$];
   int  error_count = 0;
   int  request_count = 0;
   int  dropped_count = 0;
   int  char_count = 0;
   int  cycle_count = 0;
   int  rsp_hold_cycles = 0;
   bit  req_idle_on = 1'b0;
   bit  rsp_idle_on = 1'b0;

   integer_to_ascii_formatter u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CycleLimit) begin
         $display("simulation failed");
         $finish;
      end
   end

   function automatic int idle_length(input bit enabled);
      int roll;
      roll = $urandom_range(0, 99);
      if (!enabled || roll < 70) begin
         return 0;
      end else if (roll < 93) begin
         return $urandom_range(1, 3);
      end
      return $urandom_range(8, 40);
   endfunction

   function automatic logic [7:0] digit_glyph(input logic [2:0] kind, input logic [63:0] rem);
      if (rem < 64'd10) begin
         return ChZero + rem[7:0];
      end
      return (kind == KIND_HEXU ? ChUpperA : ChLowerA) + rem[7:0] - 8'd10;
   endfunction

   // Builds the text one request should produce and queues it character by character.
   function automatic void format_request(input logic [2:0] kind, input logic [63:0] value,
         input logic wide, input logic [5:0] width, input logic lj, input logic zp,
         input logic [1:0] sm);
      logic [7:0]  text[$];
      logic [7:0]  digits[$];
      logic [63:0] mag;
      logic [63:0] radix;
      logic [7:0]  sign_ch;
      logic        neg;
      int          w;
      int          pad;
      if (kind > KIND_CHAR) begin
         dropped_count++;
         return;
      end
      request_count++;
      w = (width > FieldWidthCap) ? FieldWidthCap : width;
      if (kind == KIND_CHAR) begin
         pad = (w > 1) ? w - 1 : 0;
         if (lj) begin
            text.push_back(value[7:0]);
         end
         repeat (pad) text.push_back(ChSpace);
         if (!lj) begin
            text.push_back(value[7:0]);
         end
      end else begin
         if (!wide) begin
            value[63:32] = '0;
         end
         mag = value;
         sign_ch = 8'h00;
         if (kind == KIND_SDEC) begin
            neg = wide ? value[63] : value[31];
            if (neg) begin
               mag = 64'd0 - value;
               if (!wide) begin
                  mag[63:32] = '0;
               end
               sign_ch = ChMinus;
            end else if (value != 64'd0) begin
               if (sm == SIGN_PLUS) begin
                  sign_ch = ChPlus;
               end else if (sm == SIGN_SPACE) begin
                  sign_ch = ChSpace;
               end
            end
         end
         if (sign_ch != 8'h00) begin
            text.push_back(sign_ch);
            if (w > 0) begin
               w--;
            end
         end
         radix = (kind <= KIND_UDEC) ? 64'd10 : (kind == KIND_OCT ? 64'd8 : 64'd16);
         do begin
            digits.push_front(digit_glyph(kind, mag % radix));
            mag = mag / radix;
         end while (mag != 64'd0);
         pad = (w > digits.size()) ? w - digits.size() : 0;
         if (!lj) begin
            repeat (pad) text.push_back(zp ? ChZero : ChSpace);
         end
         foreach (digits[i]) begin
            text.push_back(digits[i]);
         end
         if (lj) begin
            repeat (pad) text.push_back(ChSpace);
         end
      end
      foreach (text[i]) begin
         expected_text.push_back('{ch: text[i], last: (i == text.size() - 1)});
      end
   endfunction

   always @(posedge clock) begin
      text_char_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         char_count++;
         if (expected_text.size() == 0) begin
            $error("out_char: no character expected, actual 8'h%02h", rsp_tdata);
            error_count++;
         end else begin
            want = expected_text.pop_front();
            if (rsp_tdata !== want.ch) begin
               $error("out_char: expected 8'h%02h, actual 8'h%02h", want.ch, rsp_tdata);
               error_count++;
            end
            if (rsp_tlast !== want.last) begin
               $error("is_last: expected %0b, actual %0b", want.last, rsp_tlast);
               error_count++;
            end
         end
      end
   end

   // Receiver: random stalls, or one long hold-off when a test asks for it.
   initial begin
      int stall;
      forever begin
         @(posedge clock);
         if (rsp_hold_cycles > 0) begin
            rsp_tready <= 1'b0;
            repeat (rsp_hold_cycles - 1) @(posedge clock);
            rsp_hold_cycles = 0;
         end else begin
            stall = ($urandom_range(0, 99) < 30) ? idle_length(rsp_idle_on) : 0;
            rsp_tready <= (stall == 0);
            if (stall > 1) begin
               repeat (stall - 1) @(posedge clock);
            end
         end
      end
   end

   task automatic send_request(input logic [2:0] kind, input logic [63:0] value,
         input logic wide, input logic [5:0] width, input logic lj, input logic zp,
         input logic [1:0] sm);
      int gap;
      req_tvalid <= 1'b1;
      req_tuser  <= kind;
      req_tdata  <= {5'b0, sm, zp, lj, width, wide, value};
      do @(posedge clock); while (!req_tready);
      format_request(kind, value, wide, width, lj, zp, sm);
      gap = idle_length(req_idle_on);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic wait_text_drained();
      req_tvalid <= 1'b0;
      while (expected_text.size() != 0) @(posedge clock);
   endtask

   task automatic send_random_request(output bit counted);
      logic [2:0]  kind;
      logic [63:0] value;
      logic [5:0]  width;
      kind = ($urandom_range(0, 99) < 6) ? ($urandom_range(0, 1) ? KIND_RSVD7 : KIND_RSVD6)
                                          : 3'($urandom_range(KIND_SDEC, KIND_CHAR));
      case ($urandom_range(0, 5))
         0: value = {$urandom, $urandom};
         1: value = 64'($urandom_range(0, 999));
         2: value = 64'd0;
         3: value = $urandom_range(0, 1) ? '1 : {1'b1, 63'($urandom_range(0, 3))};
         4: value = {$urandom, 1'b1, 31'($urandom)};
         default: value = 64'd1 << $urandom_range(0, 63);
      endcase
      width = ($urandom_range(0, 99) < 75) ? 6'($urandom_range(0, 24))
                                           : 6'($urandom_range(25, 63));
      send_request(kind, value, 1'($urandom), width, 1'($urandom), 1'($urandom),
                   2'($urandom));
      counted = (kind <= KIND_CHAR);
   endtask

   task automatic send_random_batch(input int count);
      int  sent;
      bit  counted;
      sent = 0;
      while (sent < count) begin
         send_random_request(counted);
         sent += counted;
      end
   endtask

   task automatic test_field_extremes();
      req_idle_on = 1'b1;
      rsp_idle_on = 1'b1;
      send_request(KIND_SDEC, 64'h8000_0000_0000_0000, 1'b1, 6'd0, 1'b0, 1'b0, SIGN_NONE);
      send_request(KIND_SDEC, 64'h0000_0000_8000_0000, 1'b0, 6'd0, 1'b0, 1'b0, SIGN_NONE);
      send_request(KIND_SDEC, 64'h7FFF_FFFF_FFFF_FFFF, 1'b1, 6'd63, 1'b0, 1'b1, SIGN_PLUS);
      send_request(KIND_UDEC, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 6'd0, 1'b0, 1'b0, SIGN_NONE);
      send_request(KIND_UDEC, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 6'd12, 1'b1, 1'b0, SIGN_PLUS);
      send_request(KIND_HEXL, 64'h0123_4567_89AB_CDEF, 1'b1, 6'd20, 1'b0, 1'b1, SIGN_NONE);
      send_request(KIND_HEXU, 64'h0123_4567_89AB_CDEF, 1'b1, 6'd20, 1'b1, 1'b0, SIGN_NONE);
      send_request(KIND_OCT,  64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 6'd63, 1'b1, 1'b1, SIGN_SPACE);
      send_request(KIND_CHAR, 64'hFFFF_FFFF_FFFF_FF7E, 1'b1, 6'd63, 1'b1, 1'b0, SIGN_NONE);
      send_request(KIND_CHAR, 64'h0000_0000_0000_0041, 1'b0, 6'd0, 1'b0, 1'b0, SIGN_NONE);
      send_request(KIND_CHAR, 64'h0000_0000_0000_00FF, 1'b0, 6'd1, 1'b0, 1'b0, SIGN_NONE);
   endtask

   task automatic test_special_cases();
      send_request(KIND_SDEC, 64'd0, 1'b1, 6'd5, 1'b0, 1'b0, SIGN_PLUS);
      send_request(KIND_HEXL, 64'd0, 1'b0, 6'd0, 1'b0, 1'b0, SIGN_NONE);
      send_request(KIND_SDEC, 64'd5, 1'b0, 6'd0, 1'b0, 1'b0, SIGN_PLUS);
      send_request(KIND_SDEC, 64'hFFFF_FFFF_FFFF_FFF9, 1'b1, 6'd0, 1'b0, 1'b1, SIGN_NONE);
      send_request(KIND_SDEC, 64'hFFFF_FFFF_FFFF_FFF9, 1'b1, 6'd1, 1'b0, 1'b1, SIGN_NONE);
      send_request(KIND_SDEC, 64'd42, 1'b1, 6'd4, 1'b0, 1'b0, SIGN_SPACE);
      send_request(KIND_SDEC, 64'd42, 1'b1, 6'd3, 1'b0, 1'b1, SIGN_RSVD);
      send_request(KIND_RSVD6, 64'd123, 1'b1, 6'd9, 1'b0, 1'b0, SIGN_NONE);
      send_request(KIND_RSVD7, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 6'd63, 1'b1, 1'b1, SIGN_RSVD);
      send_request(KIND_SDEC, 64'hFFFF_FFFF_FFFF_FFD6, 1'b1, 6'd10, 1'b1, 1'b1, SIGN_PLUS);
      send_request(KIND_SDEC, 64'h1234_5678_FFFF_FFFE, 1'b0, 6'd8, 1'b0, 1'b1, SIGN_NONE);
      send_request(KIND_CHAR, 64'h0000_0000_0000_0030, 1'b1, 6'd5, 1'b0, 1'b1, SIGN_PLUS);
      send_request(KIND_UDEC, 64'd0, 1'b1, 6'd3, 1'b0, 1'b1, SIGN_PLUS);
   endtask

   task automatic test_random_mix();
      req_idle_on = 1'b1;
      rsp_idle_on = 1'b1;
      send_random_batch(140);
   endtask

   task automatic test_back_to_back();
      req_idle_on = 1'b0;
      rsp_idle_on = 1'b0;
      send_random_batch(30);
   endtask

   task automatic test_receiver_hold_off();
      req_idle_on = 1'b0;
      rsp_hold_cycles = 600;
      send_random_batch(12);
   endtask

   task automatic test_sender_pause();
      req_idle_on = 1'b1;
      rsp_idle_on = 1'b1;
      send_random_batch(8);
      wait_text_drained();
      send_random_batch(8);
   endtask

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_field_extremes();
      test_special_cases();
      test_random_mix();
      test_back_to_back();
      test_receiver_hold_off();
      test_sender_pause();
      wait_text_drained();
      repeat (DrainCycles) @(posedge clock);
      $display("Formatted %0d requests into %0d characters; %0d unknown-kind requests dropped.",
               request_count, char_count, dropped_count);
      $display("Covered every kind, width and flag extreme, a long receiver stall and a pause.");
      if (error_count == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule
